### hdl/assert_macros.svh
// Concurrent assertion helpers shared by the header locator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IMHL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("imhl assertion failed");
`define IMHL_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("imhl reset assertion failed");
`else
`define IMHL_ASSERT(lbl, clk, rstn, prop)
`define IMHL_ASSERT_RST(lbl, clk, prop)
`endif
`endif

### hdl/imhl_pkg.sv
package imhl_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_NH     = 3'd1,
    ST_BAD_GRH    = 3'd2,
    ST_BAD_OPCODE = 3'd3,
    ST_SHORT      = 3'd4,
    ST_TRUNC      = 3'd5
  } status_e;

  typedef logic [6:0] offset_t;

  localparam int unsigned LRH_LEN    = 8;
  localparam int unsigned GRH_LEN    = 40;
  localparam int unsigned BTH_LEN    = 12;
  localparam int unsigned DETH_LEN   = 8;
  localparam int unsigned RDETH_LEN  = 4;
  localparam int unsigned NH_POS     = 1;
  localparam int unsigned GRH_NH_POS = LRH_LEN + 6;
  localparam int unsigned TID_OFS    = 'h8;
  localparam int unsigned TID_LEN    = 8;
  localparam int unsigned ATTR_OFS   = 'h10;
  localparam int unsigned ATTR_LEN   = 2;

  localparam offset_t BTH_POS_LRH = offset_t'(LRH_LEN);
  localparam offset_t BTH_POS_GRH = offset_t'(LRH_LEN + GRH_LEN);
  localparam offset_t RD_EXT      = offset_t'(BTH_LEN + RDETH_LEN + DETH_LEN);
  localparam offset_t UD_EXT      = offset_t'(BTH_LEN + DETH_LEN);

  localparam logic [7:0] GRH_NH_IB = 8'h1b;

  localparam logic [1:0] NH_GRH = 2'd3;
  localparam logic [1:0] NH_BTH = 2'd2;

  localparam logic [2:0] CLS_RD = 3'd2;
  localparam logic [2:0] CLS_UD = 3'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } word_t;

  typedef struct packed {
    status_e     status;
    offset_t     mad_offset;
    logic [63:0] transaction_id;
    logic [15:0] attribute_id;
  } result_t;

endpackage

### hdl/imhl_intf.sv
interface imhl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface imhl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  mad_offset;
  logic [63:0] transaction_id;
  logic [15:0] attribute_id;

  modport source (
    output valid, output status, output mad_offset, output transaction_id,
    output attribute_id, input ready
  );
  modport sink (
    input valid, input status, input mad_offset, input transaction_id,
    input attribute_id, output ready
  );
endinterface

### hdl/ib_mad_header_locator.sv
// A last byte passes through the input register; its result then loads the result register.
// Throughput: one byte per cycle, back to back, while the result side keeps up.
// A stalled result holds in the result register; bytes of the next packet keep advancing
// and only its last byte waits in the input register.
// Reset: asynchronous, active low; clears the packet state and both valid flags.
`include "assert_macros.svh"

module ib_mad_header_locator #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input logic        clk_i,
  input logic        rst_ni,
  imhl_in_if.sink    in_i,
  imhl_out_if.source out_o
);

  logic              in_valid_q, out_valid_q;
  imhl_pkg::word_t   word_q;
  imhl_pkg::result_t res_q, res_now;
  logic              out_free, advance, load_res;

  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = in_valid_q && (!word_q.last_byte || out_free);
  assign load_res = advance && word_q.last_byte;
  assign in_i.ready = !in_valid_q || advance;

  imhl_parse #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .word_i  (word_q),
    .result_o(res_now)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      word_q.data_byte <= in_i.data_byte;
      word_q.last_byte <= in_i.last_byte;
    end
    if (load_res) begin
      res_q <= res_now;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = res_q.status;
  assign out_o.mad_offset     = res_q.mad_offset;
  assign out_o.transaction_id = res_q.transaction_id;
  assign out_o.attribute_id   = res_q.attribute_id;

  function automatic logic err_fields_clear(imhl_pkg::result_t r);
    return r.status == imhl_pkg::ST_OK
           || (r.mad_offset == '0 && r.transaction_id == '0 && r.attribute_id == '0);
  endfunction

  function automatic logic ok_offset_known(imhl_pkg::result_t r);
    return r.status != imhl_pkg::ST_OK
           || r.mad_offset == imhl_pkg::BTH_POS_LRH + imhl_pkg::UD_EXT
           || r.mad_offset == imhl_pkg::BTH_POS_LRH + imhl_pkg::RD_EXT
           || r.mad_offset == imhl_pkg::BTH_POS_GRH + imhl_pkg::UD_EXT
           || r.mad_offset == imhl_pkg::BTH_POS_GRH + imhl_pkg::RD_EXT;
  endfunction

  `IMHL_ASSERT(a_error_zero_fields, clk_i, rst_ni, out_valid_q |-> err_fields_clear(res_q))
  `IMHL_ASSERT(a_ok_offset_known, clk_i, rst_ni, out_valid_q |-> ok_offset_known(res_q))
  `IMHL_ASSERT(a_result_needs_last, clk_i, rst_ni, $rose(out_valid_q) |-> $past(load_res))
  `IMHL_ASSERT_RST(a_reset_no_result, clk_i, !rst_ni |=> !out_valid_q)

endmodule

### hdl/imhl_parse.sv
`include "assert_macros.svh"

module imhl_parse #(
  parameter int unsigned MAX_PACKET_BYTES = 4096,
  localparam int unsigned PosWidth = $clog2(MAX_PACKET_BYTES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  imhl_pkg::word_t   word_i,
  output imhl_pkg::result_t result_o
);

  localparam logic [PosWidth-1:0] PosMax = PosWidth'(MAX_PACKET_BYTES);

  logic [PosWidth-1:0] pos_q, count;
  logic                grh_q, grh_d;
  imhl_pkg::offset_t   off_q, off_d, bth_pos, tid_lo, tid_hi, attr_hi;
  imhl_pkg::status_e   err_q, err_d, status;
  logic [63:0]         tid_q, tid_d;
  logic [15:0]         attr_q, attr_d;
  logic                in_range;
  logic [7:0]          b;

  assign b        = word_i.data_byte;
  assign in_range = pos_q < PosMax;
  assign bth_pos  = grh_q ? imhl_pkg::BTH_POS_GRH : imhl_pkg::BTH_POS_LRH;
  assign tid_lo   = off_q + imhl_pkg::offset_t'(imhl_pkg::TID_OFS);
  assign tid_hi   = off_q + imhl_pkg::offset_t'(imhl_pkg::TID_OFS + imhl_pkg::TID_LEN);
  assign attr_hi  = off_q + imhl_pkg::offset_t'(imhl_pkg::ATTR_OFS + imhl_pkg::ATTR_LEN);
  assign count    = in_range ? pos_q + PosWidth'(1) : PosMax;

  always_comb begin
    grh_d  = grh_q;
    off_d  = off_q;
    err_d  = err_q;
    tid_d  = tid_q;
    attr_d = attr_q;
    if (in_range && err_q == imhl_pkg::ST_OK) begin
      if (pos_q == PosWidth'(imhl_pkg::NH_POS)) begin
        case (b[1:0])
          imhl_pkg::NH_GRH: grh_d = 1'b1;
          imhl_pkg::NH_BTH: grh_d = 1'b0;
          default:          err_d = imhl_pkg::ST_BAD_NH;
        endcase
      end else if (grh_q && pos_q == PosWidth'(imhl_pkg::GRH_NH_POS)
                   && b != imhl_pkg::GRH_NH_IB) begin
        err_d = imhl_pkg::ST_BAD_GRH;
      end else if (pos_q == PosWidth'(bth_pos)) begin
        case (b[7:5])
          imhl_pkg::CLS_RD: off_d = bth_pos + imhl_pkg::RD_EXT;
          imhl_pkg::CLS_UD: off_d = bth_pos + imhl_pkg::UD_EXT;
          default:          err_d = imhl_pkg::ST_BAD_OPCODE;
        endcase
      end else if (off_q != '0) begin
        if (pos_q >= PosWidth'(tid_lo) && pos_q < PosWidth'(tid_hi)) begin
          tid_d = {tid_q[55:0], b};
        end else if (pos_q >= PosWidth'(tid_hi) && pos_q < PosWidth'(attr_hi)) begin
          attr_d = {attr_q[7:0], b};
        end
      end
    end
  end

  always_comb begin
    if (err_d != imhl_pkg::ST_OK) begin
      status = err_d;
    end else if (off_d == '0 || PosWidth'(off_d) >= count) begin
      status = imhl_pkg::ST_SHORT;
    end else if (count < PosWidth'(off_d + imhl_pkg::offset_t'(imhl_pkg::ATTR_OFS
                                             + imhl_pkg::ATTR_LEN))) begin
      status = imhl_pkg::ST_TRUNC;
    end else begin
      status = imhl_pkg::ST_OK;
    end
    result_o.status         = status;
    result_o.mad_offset     = '0;
    result_o.transaction_id = '0;
    result_o.attribute_id   = '0;
    if (status == imhl_pkg::ST_OK) begin
      result_o.mad_offset     = off_d;
      result_o.transaction_id = tid_d;
      result_o.attribute_id   = attr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      grh_q  <= 1'b0;
      off_q  <= '0;
      err_q  <= imhl_pkg::ST_OK;
      tid_q  <= '0;
      attr_q <= '0;
    end else if (step_i) begin
      if (word_i.last_byte) begin
        pos_q  <= '0;
        grh_q  <= 1'b0;
        off_q  <= '0;
        err_q  <= imhl_pkg::ST_OK;
        tid_q  <= '0;
        attr_q <= '0;
      end else begin
        pos_q  <= count;
        grh_q  <= grh_d;
        off_q  <= off_d;
        err_q  <= err_d;
        tid_q  <= tid_d;
        attr_q <= attr_d;
      end
    end
  end

  `IMHL_ASSERT(a_pos_saturates, clk_i, rst_ni, pos_q <= PosMax)
  `IMHL_ASSERT(a_offset_no_error, clk_i, rst_ni, off_q != '0 |-> err_q == imhl_pkg::ST_OK)
  `IMHL_ASSERT(a_far_offset_grh, clk_i, rst_ni, (off_q == 7'd68 || off_q == 7'd72) |-> grh_q)

endmodule

### dv/ib_mad_header_locator_checker.sv
`timescale 1ns / 100ps

module ib_mad_header_locator_checker #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  imhl_in_if          pkt_i,
  imhl_out_if         res_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  int unsigned         byte_pos;
  logic                grh_seen;
  imhl_pkg::offset_t   mad_ofs;
  imhl_pkg::status_e   pkt_err;
  logic [63:0]         tid_acc;
  logic [15:0]         attr_acc;
  imhl_pkg::result_t   expected_results[$];
  int unsigned         mismatches = 0;

  assign mismatch_cnt_o = mismatches;

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic restart_packet();
    byte_pos = 0;
    grh_seen = 1'b0;
    mad_ofs  = '0;
    pkt_err  = imhl_pkg::ST_OK;
    tid_acc  = '0;
    attr_acc = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    imhl_pkg::result_t want;
    imhl_pkg::status_e st;
    int unsigned       bth_at;
    int unsigned       count;
    logic [7:0]        b;
    if (!rst_ni) begin
      restart_packet();
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result word with no packet pending", 64'(res_i.status), 64'(0));
        end else begin
          want = expected_results.pop_front();
          if (res_i.status !== want.status) begin
            note_mismatch("status", 64'(res_i.status), 64'(want.status));
          end
          if (res_i.mad_offset !== want.mad_offset) begin
            note_mismatch("mad_offset", 64'(res_i.mad_offset), 64'(want.mad_offset));
          end
          if (res_i.transaction_id !== want.transaction_id) begin
            note_mismatch("transaction_id", res_i.transaction_id, want.transaction_id);
          end
          if (res_i.attribute_id !== want.attribute_id) begin
            note_mismatch("attribute_id", 64'(res_i.attribute_id), 64'(want.attribute_id));
          end
        end
      end
      if (pkt_i.valid && pkt_i.ready) begin
        b = pkt_i.data_byte;
        bth_at = grh_seen ? imhl_pkg::BTH_POS_GRH : imhl_pkg::BTH_POS_LRH;
        if (byte_pos < MAX_PACKET_BYTES) begin
          if (pkt_err == imhl_pkg::ST_OK) begin
            if (byte_pos == imhl_pkg::NH_POS) begin
              case (b[1:0])
                imhl_pkg::NH_GRH: grh_seen = 1'b1;
                imhl_pkg::NH_BTH: grh_seen = 1'b0;
                default:          pkt_err = imhl_pkg::ST_BAD_NH;
              endcase
            end else if (grh_seen && byte_pos == imhl_pkg::GRH_NH_POS
                         && b != imhl_pkg::GRH_NH_IB) begin
              pkt_err = imhl_pkg::ST_BAD_GRH;
            end else if (byte_pos == bth_at) begin
              case (b[7:5])
                imhl_pkg::CLS_RD: mad_ofs = imhl_pkg::offset_t'(bth_at + imhl_pkg::RD_EXT);
                imhl_pkg::CLS_UD: mad_ofs = imhl_pkg::offset_t'(bth_at + imhl_pkg::UD_EXT);
                default:          pkt_err = imhl_pkg::ST_BAD_OPCODE;
              endcase
            end else if (mad_ofs != 0) begin
              if (byte_pos >= mad_ofs + imhl_pkg::TID_OFS &&
                  byte_pos < mad_ofs + imhl_pkg::TID_OFS + imhl_pkg::TID_LEN) begin
                tid_acc = {tid_acc[55:0], b};
              end else if (byte_pos >= mad_ofs + imhl_pkg::ATTR_OFS &&
                           byte_pos < mad_ofs + imhl_pkg::ATTR_OFS + imhl_pkg::ATTR_LEN) begin
                attr_acc = {attr_acc[7:0], b};
              end
            end
          end
          count = byte_pos + 1;
        end else begin
          count = MAX_PACKET_BYTES;
        end
        if (!pkt_i.last_byte) begin
          byte_pos = count;
        end else begin
          if (pkt_err != imhl_pkg::ST_OK) begin
            st = pkt_err;
          end else if (mad_ofs == 0 || mad_ofs >= count) begin
            st = imhl_pkg::ST_SHORT;
          end else if (count < mad_ofs + imhl_pkg::ATTR_OFS + imhl_pkg::ATTR_LEN) begin
            st = imhl_pkg::ST_TRUNC;
          end else begin
            st = imhl_pkg::ST_OK;
          end
          want = '0;
          want.status = st;
          if (st == imhl_pkg::ST_OK) begin
            want.mad_offset     = mad_ofs;
            want.transaction_id = tid_acc;
            want.attribute_id   = attr_acc;
          end
          expected_results.push_back(want);
          restart_packet();
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

### dv/ib_mad_header_locator_tb.sv
`timescale 1ns / 100ps

module ib_mad_header_locator_tb;

  localparam int unsigned MAX_PKT          = 128;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned STALL_LIMIT      = 2000;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned holds_req      = 0;
  int unsigned mismatch_cnt;
  int unsigned pending;

  imhl_in_if  pkt_if ();
  imhl_out_if res_if ();

  ib_mad_header_locator #(
    .MAX_PACKET_BYTES(MAX_PKT)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pkt_if),
    .out_o  (res_if)
  );

  ib_mad_header_locator_checker #(
    .MAX_PACKET_BYTES(MAX_PKT)
  ) mad_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pkt_i          (pkt_if),
    .res_i          (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned mad_ofs_for(input logic [1:0] nh, input logic [2:0] cls);
    return ((nh == imhl_pkg::NH_GRH) ? imhl_pkg::BTH_POS_GRH : imhl_pkg::BTH_POS_LRH)
           + ((cls == imhl_pkg::CLS_RD) ? imhl_pkg::RD_EXT : imhl_pkg::UD_EXT);
  endfunction

  task automatic send_packet(input logic [1:0] nh, input logic [2:0] cls,
                             input logic [7:0] grh_chk, input int unsigned len,
                             input fill_e fill);
    int unsigned bth_at;
    logic [7:0]  b;
    bth_at = (nh == imhl_pkg::NH_GRH) ? imhl_pkg::BTH_POS_GRH : imhl_pkg::BTH_POS_LRH;
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hff;
        default:   b = 8'($urandom);
      endcase
      if (i == imhl_pkg::NH_POS) begin
        b[1:0] = nh;
      end else if (nh == imhl_pkg::NH_GRH && i == imhl_pkg::GRH_NH_POS) begin
        b = grh_chk;
      end else if (i == bth_at) begin
        b[7:5] = cls;
      end
      while ($urandom_range(99) < src_idle_pct) begin
        pkt_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      pkt_if.valid     <= 1'b1;
      pkt_if.data_byte <= b;
      pkt_if.last_byte <= (i == len - 1);
      @(posedge clk_i);
      while (!pkt_if.ready) @(posedge clk_i);
    end
  endtask

  initial begin : sink_drive
    int unsigned holds_done;
    holds_done = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_req > holds_done) begin
        holds_done++;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]  nh;
    logic [2:0]  cls;
    logic [7:0]  chk;
    int unsigned ofs;
    int unsigned len;
    int unsigned pick;
    rst_ni           <= 1'b0;
    pkt_if.valid     <= 1'b0;
    pkt_if.data_byte <= 8'h00;
    pkt_if.last_byte <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    holds_req++;
    send_packet(imhl_pkg::NH_BTH, imhl_pkg::CLS_UD, imhl_pkg::GRH_NH_IB, 1, FILL_ZERO);
    send_packet(imhl_pkg::NH_GRH, imhl_pkg::CLS_RD, imhl_pkg::GRH_NH_IB, 2, FILL_ONES);
    send_packet(2'd0, imhl_pkg::CLS_UD, imhl_pkg::GRH_NH_IB, 10, FILL_RANDOM);
    send_packet(2'd1, imhl_pkg::CLS_UD, imhl_pkg::GRH_NH_IB, 12, FILL_ONES);
    send_packet(imhl_pkg::NH_GRH, imhl_pkg::CLS_UD, 8'h1a, 16, FILL_RANDOM);
    send_packet(imhl_pkg::NH_GRH, imhl_pkg::CLS_UD, imhl_pkg::GRH_NH_IB, 14, FILL_RANDOM);
    send_packet(imhl_pkg::NH_GRH, imhl_pkg::CLS_UD, imhl_pkg::GRH_NH_IB, 15, FILL_RANDOM);
    for (int c = 0; c < 8; c++) begin
      send_packet(imhl_pkg::NH_BTH, 3'(c), imhl_pkg::GRH_NH_IB, 10, FILL_RANDOM);
    end
    send_packet(imhl_pkg::NH_GRH, 3'd7, imhl_pkg::GRH_NH_IB, 50, FILL_ONES);
    send_packet(imhl_pkg::NH_BTH, imhl_pkg::CLS_RD, imhl_pkg::GRH_NH_IB,
                mad_ofs_for(imhl_pkg::NH_BTH, imhl_pkg::CLS_RD) + 18, FILL_ONES);
    send_packet(imhl_pkg::NH_GRH, imhl_pkg::CLS_UD, imhl_pkg::GRH_NH_IB,
                mad_ofs_for(imhl_pkg::NH_GRH, imhl_pkg::CLS_UD) + 18, FILL_ZERO);
    send_packet(imhl_pkg::NH_BTH, imhl_pkg::CLS_UD, imhl_pkg::GRH_NH_IB,
                mad_ofs_for(imhl_pkg::NH_BTH, imhl_pkg::CLS_UD) + 17, FILL_RANDOM);
    send_packet(imhl_pkg::NH_BTH, imhl_pkg::CLS_UD, imhl_pkg::GRH_NH_IB,
                mad_ofs_for(imhl_pkg::NH_BTH, imhl_pkg::CLS_UD), FILL_RANDOM);
    send_packet(imhl_pkg::NH_BTH, imhl_pkg::CLS_UD, imhl_pkg::GRH_NH_IB, MAX_PKT + 4,
                FILL_RANDOM);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 84;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 84;
        end
        default: begin
          src_idle_pct   = 12;
          sink_stall_pct = 12;
        end
      endcase
      for (int k = 0; k < 2; k++) begin
        nh   = ($urandom_range(1) != 0) ? imhl_pkg::NH_GRH : imhl_pkg::NH_BTH;
        cls  = ($urandom_range(1) != 0) ? imhl_pkg::CLS_RD : imhl_pkg::CLS_UD;
        chk  = imhl_pkg::GRH_NH_IB;
        ofs  = mad_ofs_for(nh, cls);
        pick = $urandom_range(99);
        if (pick < 60) begin
          len = ofs + imhl_pkg::ATTR_OFS + imhl_pkg::ATTR_LEN +
                (($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(2));
        end else if (pick < 70) begin
          len = $urandom_range(ofs + 17, ofs + 1);
        end else if (pick < 78) begin
          len = $urandom_range(ofs, 1);
        end else if (pick < 84) begin
          nh  = 2'($urandom_range(1));
          len = $urandom_range(30, 2);
        end else if (pick < 90) begin
          nh  = imhl_pkg::NH_GRH;
          chk = 8'($urandom);
          if (chk == imhl_pkg::GRH_NH_IB) chk = ~chk;
          len = $urandom_range(50, 15);
        end else if (pick < 96) begin
          do cls = 3'($urandom); while (cls == imhl_pkg::CLS_RD || cls == imhl_pkg::CLS_UD);
          len = $urandom_range(60, 50);
        end else begin
          nh  = 2'($urandom);
          cls = 3'($urandom);
          chk = 8'($urandom);
          len = $urandom_range(60, 1);
        end
        send_packet(nh, cls, chk, len, FILL_RANDOM);
      end
    end

    pkt_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
